@@ rtl/mfhp_pkg.sv @@
package mfhp_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_TITLE = 3'd0;
    localparam logic [2:0] KIND_BASE  = 3'd1;
    localparam logic [2:0] KIND_VOICE = 3'd2;
    localparam logic [2:0] KIND_CHAN  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NO_MARKER  = 2'd0;
    localparam logic [1:0] ERR_NAME_OPEN  = 2'd1;
    localparam logic [1:0] ERR_OFFSET     = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

    // Title terminator bytes and the name terminator.
    localparam logic [7:0] MARK_CR   = 8'h0D;
    localparam logic [7:0] MARK_LF   = 8'h0A;
    localparam logic [7:0] MARK_EOF  = 8'h1A;
    localparam logic [7:0] NAME_TERM = 8'h00;

    // Channel table layout.
    localparam logic [24:0] EXT_THRESHOLD = 25'h22;
    localparam logic [4:0]  LAST_PAIR_STD = 5'd9;
    localparam logic [4:0]  LAST_PAIR_EXT = 5'd16;

    // Division by the 27-byte voice record size: q = (x * DIV27_MULT) >> DIV27_SHIFT,
    // exact for every 24-bit dividend.
    localparam int          DIV27_SHIFT = 29;
    localparam logic [24:0] DIV27_MULT  = 25'd19884108;

    typedef enum logic [4:0] {
        PH_TITLE   = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_OFFSETS = 5'b00100,
        PH_DONE    = 5'b01000,
        PH_STOPPED = 5'b10000
    } phase_t;

    // One parse result on its way to the output stage. span carries the byte
    // count from the voice table to the end of file for voice results.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [23:0] value;
        logic [23:0] span;
        logic [1:0]  err;
        logic        done;
    } res_t;

endpackage

@@ rtl/mfhp_parse.sv @@
module mfhp_parse #(
    parameter int POSITION_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          first,
    input  logic [23:0]   file_length,
    output logic          hit,
    output mfhp_pkg::res_t res
);
    import mfhp_pkg::*;

    localparam logic [POSITION_BITS-1:0] PMAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    phase_t                   phase_reg, phase_next;
    logic [15:0]              prev_reg, prev_next;
    logic [23:0]              base_reg, base_next;
    logic [7:0]               high_reg, high_next;
    logic [4:0]               idx_reg, idx_next;
    logic                     lowexp_reg, lowexp_next;
    logic                     ext_reg, ext_next;

    always_comb
    begin
        logic [POSITION_BITS-1:0] pos_e;
        phase_t      phase_e;
        logic [15:0] prev_e;
        logic [23:0] base_e;
        logic [7:0]  high_e;
        logic [4:0]  idx_e;
        logic        lowexp_e;
        logic        ext_e;
        logic [31:0] p32;
        logic [31:0] len32;
        logic [23:0] p24;
        logic        last;
        logic        fail_en;
        logic [1:0]  fail_code;
        logic [24:0] off;
        logic        ext_use;
        logic        fin;

        pos_e    = first ? '0 : pos_reg;
        phase_e  = first ? PH_TITLE : phase_reg;
        prev_e   = first ? 16'd0 : prev_reg;
        base_e   = first ? 24'd0 : base_reg;
        high_e   = first ? 8'd0 : high_reg;
        idx_e    = first ? 5'd0 : idx_reg;
        lowexp_e = first ? 1'b0 : lowexp_reg;
        ext_e    = first ? 1'b0 : ext_reg;

        pos_next    = (pos_e != PMAX) ? pos_e + 1'b1 : pos_e;
        phase_next  = phase_e;
        prev_next   = prev_e;
        base_next   = base_e;
        high_next   = high_e;
        idx_next    = idx_e;
        lowexp_next = lowexp_e;
        ext_next    = ext_e;

        p32   = 32'(pos_e);
        len32 = 32'(file_length);
        p24   = p32[23:0];
        last  = (p32 + 32'd1 == len32);
        off   = {1'b0, base_e} + {9'd0, high_e, data_byte};
        ext_use = ext_e;
        fin     = 1'b0;

        fail_en   = 1'b0;
        fail_code = ERR_NO_MARKER;
        hit       = 1'b0;
        res       = '0;

        unique case (phase_e) inside
            PH_DONE, PH_STOPPED:
            begin
                // Quiet until the next file starts.
            end
            PH_TITLE:
            begin
                if (p32 >= len32)
                begin
                    fail_en = 1'b1;
                    fail_code = ERR_NO_MARKER;
                end
                else
                begin
                    prev_next = {prev_e[7:0], data_byte};
                    if (prev_e == {MARK_CR, MARK_LF} && data_byte == MARK_EOF)
                    begin
                        if (last)
                        begin
                            fail_en = 1'b1;
                            fail_code = ERR_NAME_OPEN;
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                            hit = 1'b1;
                            res.kind = KIND_TITLE;
                            res.value = p24 - 24'd2;
                        end
                    end
                    else if (last)
                    begin
                        fail_en = 1'b1;
                        fail_code = ERR_NO_MARKER;
                    end
                end
            end
            PH_NAME:
            begin
                if (p32 >= len32)
                begin
                    fail_en = 1'b1;
                    fail_code = ERR_NAME_OPEN;
                end
                else if (data_byte == NAME_TERM)
                begin
                    if (last)
                    begin
                        fail_en = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        base_next = p24 + 24'd1;
                        phase_next = PH_OFFSETS;
                        idx_next = 5'd0;
                        lowexp_next = 1'b0;
                        ext_next = 1'b0;
                        hit = 1'b1;
                        res.kind = KIND_BASE;
                        res.value = p24 + 24'd1;
                    end
                end
                else if (last)
                begin
                    fail_en = 1'b1;
                    fail_code = ERR_NAME_OPEN;
                end
            end
            PH_OFFSETS:
            begin
                if (p32 >= len32)
                begin
                    fail_en = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
                else if (!lowexp_e)
                begin
                    high_next = data_byte;
                    lowexp_next = 1'b1;
                    if (last)
                    begin
                        fail_en = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                end
                else
                begin
                    lowexp_next = 1'b0;
                    if (off > {1'b0, file_length})
                    begin
                        fail_en = 1'b1;
                        fail_code = ERR_OFFSET;
                    end
                    else if (idx_e == 5'd0)
                    begin
                        idx_next = 5'd1;
                        if (last)
                        begin
                            fail_en = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            hit = 1'b1;
                            res.kind = KIND_VOICE;
                            res.value = off[23:0];
                            res.span = file_length - off[23:0];
                        end
                    end
                    else
                    begin
                        // The first channel offset decides the table size.
                        if (idx_e == 5'd1)
                        begin
                            ext_use = (off >= {1'b0, base_e} + EXT_THRESHOLD);
                        end
                        ext_next = ext_use;
                        fin = ext_use ? (idx_e >= LAST_PAIR_EXT) : (idx_e >= LAST_PAIR_STD);
                        idx_next = idx_e + 5'd1;
                        if (fin)
                        begin
                            phase_next = PH_DONE;
                        end
                        if (!fin && last)
                        begin
                            fail_en = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            hit = 1'b1;
                            res.kind = KIND_CHAN;
                            res.channel = 4'(idx_e - 5'd1);
                            res.value = off[23:0];
                            res.done = fin;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (fail_en)
        begin
            phase_next = PH_STOPPED;
            hit = 1'b1;
            res = '0;
            res.kind = KIND_ERROR;
            res.err = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_TITLE;
            prev_reg   <= 16'd0;
            base_reg   <= 24'd0;
            high_reg   <= 8'd0;
            idx_reg    <= 5'd0;
            lowexp_reg <= 1'b0;
            ext_reg    <= 1'b0;
        end
        else if (take)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            base_reg   <= base_next;
            high_reg   <= high_next;
            idx_reg    <= idx_next;
            lowexp_reg <= lowexp_next;
            ext_reg    <= ext_next;
        end
    end

endmodule

@@ rtl/mfhp_vcount.sv @@
module mfhp_vcount (
    input  logic           clk,
    input  logic           load,
    input  mfhp_pkg::res_t mid,
    output logic [2:0]     kind,
    output logic [3:0]     channel,
    output logic [23:0]    value,
    output logic [19:0]    record_count,
    output logic [1:0]     error_code,
    output logic           header_done
);
    import mfhp_pkg::*;

    logic [48:0] product;
    logic [2:0]  kind_reg;
    logic [3:0]  channel_reg;
    logic [23:0] value_reg;
    logic [19:0] count_reg;
    logic [1:0]  err_reg;
    logic        done_reg;

    // Span is zero for every kind but the voice result, so the quotient is too.
    assign product = {25'd0, mid.span} * {24'd0, DIV27_MULT};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= mid.kind;
            channel_reg <= mid.channel;
            value_reg   <= mid.value;
            count_reg   <= product[DIV27_SHIFT +: 20];
            err_reg     <= mid.err;
            done_reg    <= mid.done;
        end
    end

    assign kind         = kind_reg;
    assign channel      = channel_reg;
    assign value        = value_reg;
    assign record_count = count_reg;
    assign error_code   = err_reg;
    assign header_done  = done_reg;

endmodule

@@ rtl/music_file_header_parser.sv @@
// Streaming header parser for a music data file. Write file_length through
// cfg_we/cfg_wdata while the block is idle, then stream the file one byte per
// transaction, with first high on the byte at position zero. The block reports
// the start of the 0D 0A 1A title marker (title length), the offset base just
// after the zero-terminated sample-file name, the voice table offset with its
// 27-byte record count, and then nine or sixteen channel offsets, the last one
// flagged by header_done. Any failure gives a single error transaction and the
// parser then stays quiet until the next first byte. One byte is accepted
// every clock cycle while in_stall is low; each byte is held in the input
// register, its result in the parse result register and then in the output
// register fed by the voice-count reciprocal multiplier. A stalled output holds
// back the input only once all three registers are full.
module music_file_header_parser #(
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  channel,
    output logic [23:0] value,
    output logic [19:0] record_count,
    output logic [1:0]  error_code,
    output logic        header_done
);
    import mfhp_pkg::*;

    logic [23:0] file_length_reg;

    // Input register.
    logic        in_v_reg;
    logic [7:0]  byte_reg;
    logic        first_reg;

    // Parse result register.
    logic        mid_v_reg;
    res_t        mid_reg;

    logic        out_v_reg;

    logic        out_free;
    logic        mid_free;
    logic        take;
    logic        in_free;
    logic        hit;
    res_t        res;
    logic        load_out;

    // Each stage moves on when the stage after it is empty or emptying.
    assign out_free = !out_v_reg || !out_stall;
    assign load_out = mid_v_reg && out_free;
    assign mid_free = !mid_v_reg || out_free;
    assign take     = in_v_reg && mid_free;
    assign in_free  = !in_v_reg || take;
    assign in_stall = !in_free;
    assign out_valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= 24'd0;
        end
        else if (cfg_we)
        begin
            file_length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_v_reg <= in_valid;
            end
            if (mid_free)
            begin
                // A byte that causes no result leaves the middle stage empty.
                mid_v_reg <= take && hit;
            end
            if (out_free)
            begin
                out_v_reg <= mid_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free)
        begin
            byte_reg  <= data_byte;
            first_reg <= first;
        end
        if (take && hit)
        begin
            mid_reg <= res;
        end
    end

    mfhp_parse #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (byte_reg),
        .first      (first_reg),
        .file_length(file_length_reg),
        .hit        (hit),
        .res        (res)
    );

    mfhp_vcount u_vcount (
        .clk         (clk),
        .load        (load_out),
        .mid         (mid_reg),
        .kind        (kind),
        .channel     (channel),
        .value       (value),
        .record_count(record_count),
        .error_code  (error_code),
        .header_done (header_done)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import mfhp_pkg::*;

    localparam int          POSITION_BITS  = 24;
    localparam int unsigned POS_MAX        = (1 << POSITION_BITS) - 1;
    localparam int unsigned MAX_FILE_LEN   = 24'hFFFFFF;
    localparam int          WATCHDOG_LIMIT = 2000;
    // Cycles to let pass once every expected result is in. The block has three
    // stages, so a byte that produces nothing can still be in flight.
    localparam int          DRAIN_CYCLES   = 6;

    // One result transaction, in the order of the output ports.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [23:0] value;
        logic [19:0] record_count;
        logic [1:0]  error_code;
        logic        header_done;
    } header_report_t;

    // Every block input starts at a known value; reset is low from time zero.
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [23:0] cfg_wdata     = '0;
    logic        in_valid      = 1'b0;
    logic [7:0]  data_byte     = '0;
    logic        start_of_file = 1'b0;
    logic        out_stall     = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [2:0]  res_kind;
    logic [3:0]  res_channel;
    logic [23:0] res_value;
    logic [19:0] res_record_count;
    logic [1:0]  res_error_code;
    logic        res_header_done;

    // Results the header model has predicted and the block has not yet sent.
    header_report_t expected_reports[$];
    // The file currently being streamed, and where its offset table begins.
    logic [7:0]     file_image[$];
    int unsigned    image_base;

    int  mismatches   = 0;
    int  sent_bytes   = 0;
    int  idle_cycles  = 0;
    // While set, neither side inserts gaps, so back-to-back traffic is covered.
    bit  no_idle      = 1'b0;

    // Shadow copy of the parser state and of the file length register.
    logic [23:0] model_len;
    int unsigned model_pos;
    phase_t      model_phase;
    logic [15:0] model_prev;
    logic [31:0] model_base;
    logic [7:0]  model_hi;
    logic [4:0]  model_pair;
    logic        model_low_next;
    logic        model_ext;

    music_file_header_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first        (start_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (res_kind),
        .channel      (res_channel),
        .value        (res_value),
        .record_count (res_record_count),
        .error_code   (res_error_code),
        .header_done  (res_header_done)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Header model. It follows the parser one byte at a time and returns 1
    // with the expected result when the byte should produce one.
    // ------------------------------------------------------------------

    function automatic void restart_model();
        model_pos      = 0;
        model_phase    = PH_TITLE;
        model_prev     = '0;
        model_base     = '0;
        model_hi       = '0;
        model_pair     = '0;
        model_low_next = 1'b0;
        model_ext      = 1'b0;
    endfunction

    // Any failure stops the parse until the next first byte.
    function automatic header_report_t stop_parse(input logic [1:0] code);
        header_report_t r;
        model_phase  = PH_STOPPED;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic bit predict_header_byte(input logic [7:0] b, input logic f,
                                               output header_report_t r);
        logic [31:0] p;
        logic [31:0] len;
        logic [31:0] off;
        logic [4:0]  idx;
        logic        last;
        logic        hit;
        logic        fin;
        r = '0;
        if (f)
            restart_model();
        p = model_pos;
        if (model_pos < POS_MAX)
            model_pos = model_pos + 1;
        // After the header is complete or after an error the parser is quiet.
        if (model_phase == PH_DONE || model_phase == PH_STOPPED)
            return 1'b0;
        len = {8'd0, model_len};

        // A byte past the end can only happen when the length was lowered
        // mid-file or is zero; it fails with the code of the current phase.
        if (p >= len)
        begin
            if (model_phase == PH_TITLE)
                r = stop_parse(ERR_NO_MARKER);
            else if (model_phase == PH_NAME)
                r = stop_parse(ERR_NAME_OPEN);
            else
                r = stop_parse(ERR_TRUNCATED);
            return 1'b1;
        end
        last = (p + 1 == len);

        if (model_phase == PH_TITLE)
        begin
            hit        = (model_prev == {MARK_CR, MARK_LF}) && (b == MARK_EOF);
            model_prev = {model_prev[7:0], b};
            if (hit)
            begin
                // A marker on the last byte leaves the name with no room.
                if (last)
                begin
                    r = stop_parse(ERR_NAME_OPEN);
                    return 1'b1;
                end
                model_phase = PH_NAME;
                r.kind      = KIND_TITLE;
                r.value     = p[23:0] - 24'd2;
                return 1'b1;
            end
            if (last)
                r = stop_parse(ERR_NO_MARKER);
            return last;
        end

        if (model_phase == PH_NAME)
        begin
            if (b == NAME_TERM)
            begin
                // The name ends on the last byte: the offset table is missing.
                if (last)
                begin
                    r = stop_parse(ERR_TRUNCATED);
                    return 1'b1;
                end
                model_base     = p + 1;
                model_phase    = PH_OFFSETS;
                model_pair     = '0;
                model_low_next = 1'b0;
                model_ext      = 1'b0;
                r.kind         = KIND_BASE;
                r.value        = model_base[23:0];
                return 1'b1;
            end
            if (last)
                r = stop_parse(ERR_NAME_OPEN);
            return last;
        end

        // Offset table: big-endian pairs relative to the base.
        if (!model_low_next)
        begin
            model_hi       = b;
            model_low_next = 1'b1;
            if (last)
                r = stop_parse(ERR_TRUNCATED);
            return last;
        end
        model_low_next = 1'b0;
        off = model_base + {16'd0, model_hi, b};
        idx = model_pair;
        // An offset equal to the length is still in range.
        if (off > len)
        begin
            r = stop_parse(ERR_OFFSET);
            return 1'b1;
        end
        if (idx == 5'd0)
        begin
            model_pair = 5'd1;
            if (last)
            begin
                r = stop_parse(ERR_TRUNCATED);
                return 1'b1;
            end
            r.kind         = KIND_VOICE;
            r.value        = off[23:0];
            r.record_count = 20'((len - off) / 27);
            return 1'b1;
        end
        // Channel 0 decides whether the table holds nine or sixteen channels.
        if (idx == 5'd1)
            model_ext = (off >= model_base + {7'd0, EXT_THRESHOLD});
        fin        = model_ext ? (idx >= LAST_PAIR_EXT) : (idx >= LAST_PAIR_STD);
        model_pair = idx + 5'd1;
        r.kind     = KIND_CHAN;
        r.channel  = idx[3:0] - 4'd1;
        r.value    = off[23:0];
        if (fin)
        begin
            model_phase   = PH_DONE;
            r.header_done = 1'b1;
            return 1'b1;
        end
        if (last)
            r = stop_parse(ERR_TRUNCATED);
        return 1'b1;
    endfunction

    function automatic string describe_report(input header_report_t r);
        return $sformatf("kind %0d ch %0d value %0h count %0d err %0d done %0d",
                         r.kind, r.channel, r.value, r.record_count,
                         r.error_code, r.header_done);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Sends one byte transaction after a random gap. Valid stays high between
    // back-to-back bytes, and the payload holds while the block stalls.
    task automatic send_byte(input logic [7:0] b, input logic f);
        int unsigned    gap;
        header_report_t r;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= f;
        do
            @(posedge clk);
        while (in_stall);
        sent_bytes++;
        if (predict_header_byte(b, f, r))
            expected_reports.push_back(r);
    endtask

    // Streams file_image[from .. to-1]; first is raised on position zero only.
    task automatic stream_image(input int unsigned from, input int unsigned to);
        for (int unsigned i = from; i < to; i++)
            send_byte(file_image[i], i == 0);
    endtask

    // Lets every outstanding transaction drain so the block is idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The length register is only written while the parser is idle.
    task automatic set_file_length(input logic [23:0] len);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_len  = len;
    endtask

    // Builds a header: title, marker, name, zero, the voice offset and nine or sixteen
    // channel offsets within flen, save a channel 0 of 33 in a nine-channel table.
    task automatic build_header(input int unsigned title_len, input int unsigned name_len,
                                input bit ext_table, input int unsigned flen);
        int unsigned room;
        int unsigned rel;
        int unsigned pairs;
        file_image.delete();
        repeat (title_len) file_image.push_back(8'($urandom_range(0, 255)));
        file_image.push_back(MARK_CR);
        file_image.push_back(MARK_LF);
        file_image.push_back(MARK_EOF);
        repeat (name_len) file_image.push_back(8'($urandom_range(1, 255)));
        file_image.push_back(NAME_TERM);
        image_base = file_image.size();
        room = (flen > image_base) ? flen - image_base : 0;
        if (room > 65535)
            room = 65535;
        pairs = ext_table ? 17 : 10;
        for (int unsigned i = 0; i < pairs; i++)
        begin
            // Channel 0 sits often right on the nine/sixteen boundary.
            if (i == 1 && ext_table)
                rel = ($urandom_range(0, 3) == 0) ? 34
                    : $urandom_range(34, (room > 34) ? room : 34);
            else if (i == 1)
                rel = ($urandom_range(0, 3) == 0) ? 33
                    : $urandom_range(0, (room < 33) ? room : 33);
            else if ($urandom_range(0, 7) == 0)
                rel = room;
            else
                rel = $urandom_range(0, room);
            file_image.push_back(rel[15:8]);
            file_image.push_back(rel[7:0]);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A zero length fails at once; later bytes without first are ignored.
    task automatic test_empty_file();
        set_file_length(24'd0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hA5, 1'b0);
    endtask

    // The title marker ends on the last byte of the file.
    task automatic test_marker_on_last_byte();
        set_file_length(24'd3);
        send_byte(MARK_CR, 1'b1);
        send_byte(MARK_LF, 1'b0);
        send_byte(MARK_EOF, 1'b0);
    endtask

    // The name terminator is the last byte, so the offset table is missing.
    task automatic test_name_zero_on_last_byte();
        set_file_length(24'd4);
        send_byte(MARK_CR, 1'b1);
        send_byte(MARK_LF, 1'b0);
        send_byte(MARK_EOF, 1'b0);
        send_byte(NAME_TERM, 1'b0);
    endtask

    // Empty title and name at the largest length: the voice table at the
    // base gives the largest voice count, channel 0 just below the threshold
    // keeps the table at nine channels, and the offsets swing all bits.
    task automatic test_standard_table_limits();
        logic [7:0] table_bytes[20];
        table_bytes = '{8'h00, 8'h00, 8'h00, 8'h21, 8'hFF, 8'hFF, 8'h80, 8'h00,
                        8'h7F, 8'hFF, 8'h00, 8'h01, 8'h12, 8'h34, 8'hAA, 8'h55,
                        8'h55, 8'hAA, 8'hFF, 8'h00};
        set_file_length(24'hFFFFFF);
        send_byte(MARK_CR, 1'b1);
        send_byte(MARK_LF, 1'b0);
        send_byte(MARK_EOF, 1'b0);
        send_byte(NAME_TERM, 1'b0);
        foreach (table_bytes[i])
            send_byte(table_bytes[i], 1'b0);
    endtask

    // Mostly complete headers with random content, plus truncated files,
    // offsets past the end, noise, lengths changed mid-file and restarts.
    task automatic test_random_files();
        int unsigned target;
        int unsigned mode;
        int unsigned title_len;
        int unsigned name_len;
        int unsigned hdr;
        int unsigned flen;
        int unsigned cut;
        int unsigned room;
        int unsigned rel;
        int unsigned pair_sel;
        int unsigned noise_len;
        bit          ext_table;
        logic [7:0]  b;
        target = sent_bytes + 520;
        while (sent_bytes < target)
        begin
            mode      = $urandom_range(0, 99);
            no_idle   = ($urandom_range(0, 4) == 0);
            title_len = $urandom_range(0, 8);
            name_len  = $urandom_range(0, 8);
            ext_table = 1'($urandom_range(0, 1));
            hdr       = title_len + 4 + name_len + (ext_table ? 34 : 20);
            case ($urandom_range(0, 9))
                0:       flen = hdr + $urandom_range(0, MAX_FILE_LEN - hdr);
                1, 2:    flen = hdr + $urandom_range(0, 65535);
                default: flen = hdr + $urandom_range(0, 40);
            endcase
            if ($urandom_range(0, 15) == 0)
                flen = MAX_FILE_LEN;
            // Offsets past the end need a file shorter than the offset range.
            if (mode >= 75 && mode < 85)
                flen = hdr + $urandom_range(0, 40);
            build_header(title_len, name_len, ext_table, flen);

            if (mode < 60)
            begin
                set_file_length(24'(flen));
                stream_image(0, file_image.size());
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (mode < 75)
            begin
                // The file ends somewhere inside the header.
                set_file_length(24'($urandom_range(1, hdr)));
                stream_image(0, file_image.size());
            end
            else if (mode < 85)
            begin
                room     = flen - image_base;
                pair_sel = $urandom_range(0, ext_table ? 16 : 9);
                rel      = $urandom_range(room + 1, 65535);
                file_image[image_base + 2 * pair_sel]     = rel[15:8];
                file_image[image_base + 2 * pair_sel + 1] = rel[7:0];
                set_file_length(24'(flen));
                stream_image(0, file_image.size());
            end
            else if (mode < 93)
            begin
                // Noise rich in marker bytes, with stray restarts.
                set_file_length(24'($urandom_range(0, 60)));
                noise_len = $urandom_range(1, 40);
                for (int unsigned i = 0; i < noise_len; i++)
                begin
                    case ($urandom_range(0, 4))
                        0:       b = MARK_CR;
                        1:       b = MARK_LF;
                        2:       b = MARK_EOF;
                        3:       b = NAME_TERM;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(b, (i == 0) || ($urandom_range(0, 19) == 0));
                end
            end
            else
            begin
                cut = $urandom_range(1, hdr - 1);
                set_file_length(24'(flen));
                stream_image(0, cut);
                if ($urandom_range(0, 1) == 1)
                begin
                    // Lower the length to at most the current position and go on.
                    wait_drained();
                    set_file_length(24'($urandom_range(0, cut)));
                    stream_image(cut, file_image.size());
                end
                else
                begin
                    // Restart with first in the middle of the header.
                    stream_image(0, file_image.size());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, then each accepted result transaction is
    // compared with the oldest prediction.
    // ------------------------------------------------------------------
    initial
    begin : result_checker
        int unsigned    stall_cycles;
        header_report_t got;
        header_report_t want;
        forever
        begin
            stall_cycles = no_idle ? 0 : $urandom_range(0, 11);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got = {res_kind, res_channel, res_value, res_record_count,
                   res_error_code, res_header_done};
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", describe_report(got));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %s, got %s",
                                 describe_report(want), describe_report(got));
                end
            end
        end
    end

    // The run ends if no transaction is accepted on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("music_file_header_parser regression: fail");
            $finish;
        end
    end

    initial
    begin
        model_len = '0;
        restart_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_file();
        test_marker_on_last_byte();
        test_name_zero_on_last_byte();
        test_standard_table_limits();
        test_random_files();

        wait_drained();
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("music_file_header_parser regression: pass");
        else
            $display("music_file_header_parser regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mfhp_pkg.sv
rtl/mfhp_parse.sv
rtl/mfhp_vcount.sv
rtl/music_file_header_parser.sv
tb/sv/testbench.sv
